// ----- rtl/rtie_pkg.sv -----
`default_nettype none
package rtie_pkg;

  typedef enum logic [4:0] {
    CmdAdd   = 5'd0,  CmdAddu = 5'd1,  CmdSub  = 5'd2,  CmdSubu = 5'd3,
    CmdMult  = 5'd4,  CmdMultu = 5'd5, CmdDiv  = 5'd6,  CmdDivu = 5'd7,
    CmdAnd   = 5'd8,  CmdNor  = 5'd9,  CmdOr   = 5'd10, CmdXor  = 5'd11,
    CmdSll   = 5'd12, CmdSllv = 5'd13, CmdSrl  = 5'd14, CmdSra  = 5'd15,
    CmdSrlv  = 5'd16, CmdSrav = 5'd17, CmdSlt  = 5'd18, CmdSltu = 5'd19,
    CmdJr    = 5'd20, CmdJalr = 5'd21, CmdMfhi = 5'd22, CmdMflo = 5'd23
  } cmd_e;

  localparam logic [4:0]  LinkReg = 5'd31;
  localparam logic [31:0] PcStep  = 32'd4;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [31:0] instr;
    logic [31:0] cur_pc;
  } in_t;

  typedef struct packed {
    logic        wr_en;
    logic [4:0]  wr_index;
    logic [31:0] wr_value;
    logic        jump;
    logic [31:0] jump_target;
    logic        div_zero;
  } out_t;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/rtie_regfile.sv -----
`default_nettype none
// 32x32 register file, two read ports with registered data, one write port.
// Reset contents come from per-entry valid bits; an invalid entry reads zero.
module rtie_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  ra_i,
  input  logic [4:0]  rb_i,
  output logic [31:0] da_o,
  output logic [31:0] db_o,
  input  logic        we_i,
  input  logic [4:0]  wa_i,
  input  logic [31:0] wd_i
);
  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic [31:0] ra_q_d, rb_q_d;
  logic        va_q, vb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    ra_q_d <= mem[ra_i];
    rb_q_d <= mem[rb_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      va_q <= vld_q[ra_i] && (ra_i != 5'd0);
      vb_q <= vld_q[rb_i] && (rb_i != 5'd0);
      if (we_i) begin
        vld_q[wa_i] <= 1'b1;
      end
    end
  end

  assign da_o = va_q ? ra_q_d : '0;
  assign db_o = vb_q ? rb_q_d : '0;
endmodule
`default_nettype wire

// ----- rtl/rtie_divider.sv -----
`default_nettype none
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module rtie_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtie_pkg::div_req_t  req_i,
  output rtie_pkg::div_rsp_t  rsp_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, nq_q, nq_d, nr_q, nr_d, done_q, done_d;
  logic [32:0] trial;
  logic [32:0] shifted;
  logic [31:0] ma, mb;

  always_comb begin
    ma = (req_i.sgn && req_i.a[31]) ? 32'd0 - req_i.a : req_i.a;
    mb = (req_i.sgn && req_i.b[31]) ? 32'd0 - req_i.b : req_i.b;
    shifted = {rem_q, quo_q[31]};
    trial = shifted - {1'b0, den_q};
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; nq_d = nq_q; nr_d = nr_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0; quo_d = ma; den_d = mb; cnt_d = 6'd32; busy_d = 1'b1;
      nq_d = req_i.sgn && (req_i.a[31] ^ req_i.b[31]);
      nr_d = req_i.sgn && req_i.a[31];
    end else if (busy_q) begin
      // advance one quotient bit
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; nq_q <= nq_d; nr_q <= nr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = nq_q ? 32'd0 - quo_q : quo_q;
  assign rsp_o.rem  = nr_q ? 32'd0 - rem_q : rem_q;
endmodule
`default_nettype wire

// ----- rtl/r_type_integer_execute.sv -----
`default_nettype none
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid_i/stall_o  | rtie_pkg::in_t  (cmd, instr, cur_pc)
// out     | out | out_valid_o/stall_i | rtie_pkg::out_t (wr_en .. div_zero)
//
// One beat at a time. The accepting edge launches the rs/rt read; the next cycle
// executes on the read data: most ops finish there, mult registers the product
// and then loads HI/LO, div/divu wait for the bit-serial divider (skipped for a
// zero divisor). The result beat then sits in an output register. The next beat
// is accepted once the result is taken.
// Reset (async, active low) clears HI/LO and marks every register invalid,
// so registers read zero until written. A stalled output holds its beat.
module r_type_integer_execute (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtie_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rtie_pkg::out_t  out_data_o
);
  typedef enum logic [2:0] {StIdle, StRead, StMul, StDiv, StOut} state_e;

  state_e          state_q;
  rtie_pkg::in_t   item_q;
  rtie_pkg::out_t  res_q, res_d;
  logic [31:0]     hi_q, lo_q, hi_d, lo_d;
  logic [31:0]     a, b;
  logic [63:0]     prod_q;
  logic            we;
  logic [4:0]      rs, rt, rd, sa;
  rtie_pkg::div_req_t dreq;
  rtie_pkg::div_rsp_t drsp;
  logic [32:0]     slt_diff;
  logic            msg;
  logic signed [65:0] prod_w;

  assign rs = in_data_i.instr[25:21];
  assign rt = in_data_i.instr[20:16];
  assign rd = item_q.instr[15:11];
  assign sa = item_q.instr[10:6];

  rtie_regfile u_rf (
    .clk_i, .rst_ni,
    .ra_i(rs), .rb_i(rt), .da_o(a), .db_o(b),
    .we_i(we), .wa_i(res_d.wr_index), .wd_i(res_d.wr_value)
  );

  assign dreq.start = (state_q == StRead) &&
                      (item_q.cmd == rtie_pkg::CmdDiv || item_q.cmd == rtie_pkg::CmdDivu) &&
                      (b != 32'd0);
  assign dreq.sgn   = (item_q.cmd == rtie_pkg::CmdDiv);
  assign dreq.a     = a;
  assign dreq.b     = b;

  rtie_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // a/b stay valid while in StRead only; one 33x33 signed multiply covers mult and multu
  assign msg    = (item_q.cmd == rtie_pkg::CmdMult);
  assign prod_w = $signed({msg & a[31], a}) * $signed({msg & b[31], b});

  always_comb begin
    res_d = '0; hi_d = hi_q; lo_d = lo_q; we = 1'b0;
    slt_diff = {a[31], a} - {b[31], b};
    if (state_q == StRead) begin
      unique case (item_q.cmd)
        rtie_pkg::CmdAdd, rtie_pkg::CmdAddu: begin res_d.wr_en = 1'b1; res_d.wr_value = a + b; end
        rtie_pkg::CmdSub, rtie_pkg::CmdSubu: begin res_d.wr_en = 1'b1; res_d.wr_value = a - b; end
        rtie_pkg::CmdAnd:  begin res_d.wr_en = 1'b1; res_d.wr_value = a & b; end
        rtie_pkg::CmdNor:  begin res_d.wr_en = 1'b1; res_d.wr_value = ~(a | b); end
        rtie_pkg::CmdOr:   begin res_d.wr_en = 1'b1; res_d.wr_value = a | b; end
        rtie_pkg::CmdXor:  begin res_d.wr_en = 1'b1; res_d.wr_value = a ^ b; end
        rtie_pkg::CmdSll:  begin res_d.wr_en = 1'b1; res_d.wr_value = b << sa; end
        rtie_pkg::CmdSllv: begin res_d.wr_en = 1'b1; res_d.wr_value = b << a[4:0]; end
        rtie_pkg::CmdSrl:  begin res_d.wr_en = 1'b1; res_d.wr_value = b >> sa; end
        rtie_pkg::CmdSra:  begin res_d.wr_en = 1'b1; res_d.wr_value = $signed(b) >>> sa; end
        rtie_pkg::CmdSrlv: begin res_d.wr_en = 1'b1; res_d.wr_value = b >> a[4:0]; end
        rtie_pkg::CmdSrav: begin res_d.wr_en = 1'b1; res_d.wr_value = $signed(b) >>> a[4:0]; end
        rtie_pkg::CmdSlt:  begin res_d.wr_en = 1'b1; res_d.wr_value = {31'd0, slt_diff[32]}; end
        rtie_pkg::CmdSltu: begin res_d.wr_en = 1'b1; res_d.wr_value = {31'd0, a < b}; end
        rtie_pkg::CmdJr:   begin res_d.jump = 1'b1; res_d.jump_target = a; end
        rtie_pkg::CmdJalr: begin
          res_d.jump = 1'b1; res_d.jump_target = a; res_d.wr_en = 1'b1;
          res_d.wr_value = item_q.cur_pc + rtie_pkg::PcStep;
        end
        rtie_pkg::CmdMfhi: begin res_d.wr_en = 1'b1; res_d.wr_value = hi_q; end
        rtie_pkg::CmdMflo: begin res_d.wr_en = 1'b1; res_d.wr_value = lo_q; end
        rtie_pkg::CmdDiv, rtie_pkg::CmdDivu: res_d.div_zero = (b == 32'd0);
        default: ;
      endcase
      res_d.wr_index = (item_q.cmd == rtie_pkg::CmdJalr) ? rtie_pkg::LinkReg : rd;
      // drop writes to register zero
      if (!res_d.wr_en || res_d.wr_index == 5'd0) begin
        res_d.wr_en = 1'b0; res_d.wr_index = '0; res_d.wr_value = '0;
      end
      we = res_d.wr_en;
    end else if (state_q == StMul) begin
      hi_d = prod_q[63:32]; lo_d = prod_q[31:0];
    end else if (state_q == StDiv && drsp.done) begin
      hi_d = drsp.rem; lo_d = drsp.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) item_q <= in_data_i;
    if (state_q == StRead) begin
      res_q  <= res_d;
      prod_q <= prod_w[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; hi_q <= '0; lo_q <= '0;
    end else begin
      hi_q <= hi_d; lo_q <= lo_d;
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StRead;
        StRead: begin
          if (item_q.cmd == rtie_pkg::CmdMult || item_q.cmd == rtie_pkg::CmdMultu) begin
            state_q <= StMul;
          end else if (dreq.start) begin
            state_q <= StDiv;
          end else begin
            state_q <= StOut;
          end
        end
        StMul: state_q <= StOut;
        StDiv: if (drsp.done) state_q <= StOut;
        StOut: if (!out_stall_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = res_q;

  // Multiply is a 64-bit product; the register after it feeds HI/LO next cycle.
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o)) else $error("accept while beat pending");
  a_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.wr_en |-> out_data_o.wr_index == 5'd0)
    else $error("index without write");
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |=> state_q == StDiv) else $error("divider start lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut && out_stall_i |=> state_q == StOut) else $error("beat dropped");
endmodule
`default_nettype wire
